// File: src/servo_command_mapper_unit_assert.svh
// assertion macros shared by the servo command mapper rtl
`ifndef SERVO_COMMAND_MAPPER_UNIT_ASSERT_SVH
`define SERVO_COMMAND_MAPPER_UNIT_ASSERT_SVH

// condition must hold in the same cycle
`define SCM_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scm assertion failed");

// condition must hold in the following cycle
`define SCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scm assertion failed");

`endif

// File: src/scm_pkg.sv
// types and constants of the servo command mapper
`timescale 1ns / 1ps

package scm_pkg;

   localparam int NUM_CHANNELS_DEFAULT     = 8;
   localparam int SERVO_FULL_SCALE_DEFAULT = 20000;

   localparam int ACTION_W = 2;
   localparam int CH_W     = 3;
   localparam int ANGLE_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int DZ_W     = 8;
   localparam int PROD_W   = 24;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam int DIVISOR_W     = 8;
   localparam int DIV_STEP_BITS = 4;

   localparam int ANGLE_NEUTRAL        = 128;
   localparam int PART_SHIFT           = 7;
   localparam int ROVER_FIXED_CHANNELS = 4;

   localparam logic [ACTION_W-1:0] ACTION_CAL    = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_ANGLE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_THRUST = 2'd2;

   // register select is paddr bit 2
   localparam logic REG_SEL_ROVER_MODE = 1'b0;
   localparam logic REG_SEL_DEAD_ZONE  = 1'b1;

   localparam logic [1:0] THRUST_SLOT_THROTTLE = 2'd2;
   localparam logic [1:0] THRUST_SLOT_BRAKE    = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CH_W-1:0]     channel;
      logic [ANGLE_W-1:0]  angle;
      logic [VALUE_W-1:0]  cal_min;
      logic [VALUE_W-1:0]  cal_max;
      logic [VALUE_W-1:0]  cal_neutral;
   } req_word_type;

   typedef struct packed {
      logic [CH_W-1:0]    out_channel;
      logic [VALUE_W-1:0] compare_value;
      logic               error;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] cal_min;
      logic [VALUE_W-1:0] cal_max;
      logic [VALUE_W-1:0] cal_neutral;
   } cal_entry_type;

   localparam int ENTRY_W = $bits(cal_entry_type);

endpackage

// File: src/scm_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module scm_ram #(
   parameter int WIDTH = scm_pkg::ENTRY_W,
   parameter int DEPTH = scm_pkg::NUM_CHANNELS_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/scm_div.sv
// iterative restoring divider, several quotient bits per cycle
`timescale 1ns / 1ps

module scm_div #(
   parameter int DIVIDEND_W = scm_pkg::PROD_W,
   parameter int DIVISOR_W  = scm_pkg::DIVISOR_W,
   parameter int STEP_BITS  = scm_pkg::DIV_STEP_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEPS = DIVIDEND_W / STEP_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W-1:0]  rem_v;
   logic [DIVIDEND_W-1:0] num_v;

   // num holds the dividend bits still to shift out and the quotient bits shifted in
   always_comb begin
      rem_v = rem_ff;
      num_v = num_ff;
      trial = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {rem_v, num_v[DIVIDEND_W-1]};
         num_v = {num_v[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial    = trial - {1'b0, divisor_ff};
            num_v[0] = 1'b1;
         end
         rem_v = trial[DIVISOR_W-1:0];
      end
   end

   assign done = busy_ff && (cnt_ff == CNT_W'(1));

   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(STEPS);
         num_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         num_in = num_v;
         rem_in = rem_v;
         cnt_in = cnt_ff - CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

// File: src/servo_command_mapper_unit.sv
// servo command mapper: calibration table, angle mapping and car thrust mixing
//
// Calibration words (min, max, neutral) for each channel sit in a small ram with a
// registered read; per-entry flags cleared at reset make unwritten entries
// read as zero, so there is no clearing pass. A calibration word gives no result.
// Set-angle words flow one per cycle while no stall holds them: table read, one 16x8
// multiply, the stage 2 registers, then the output register. In rover mode a
// car-thrust word has its dividends formed, then runs through the radix-16 dividers
// (throttle and brake side by side, divisor 128 - dead_zone/2), then four results at
// one per cycle while the output is not stalled. Mode and channel errors give one result.
`timescale 1ns / 1ps

module servo_command_mapper_unit #(
   parameter int NUM_CHANNELS     = scm_pkg::NUM_CHANNELS_DEFAULT,
   parameter int SERVO_FULL_SCALE = scm_pkg::SERVO_FULL_SCALE_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  scm_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output scm_pkg::rsp_word_type        rsp_word,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [scm_pkg::PADDR_W-1:0]  paddr,
   input  logic [scm_pkg::PDATA_W-1:0]  pwdata,
   output logic [scm_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   import scm_pkg::*;

`include "servo_command_mapper_unit_assert.svh"

   localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHK_W = CH_W + 2;
   localparam logic [CHK_W-1:0]   NUM_CH     = CHK_W'(NUM_CHANNELS);
   localparam logic [VALUE_W-1:0] FULL_SCALE = VALUE_W'(SERVO_FULL_SCALE);

   typedef enum logic [3:0] {
      S2_IDLE   = 4'b0001,
      S2_SINGLE = 4'b0010,
      S2_DIVIDE = 4'b0100,
      S2_THRUST = 4'b1000
   } s2_state_type;

   // configuration registers
   logic              rover_mode_ff, rover_mode_in;
   logic [DZ_W-1:0]   dead_zone_ff, dead_zone_in;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      rover_mode_in = rover_mode_ff;
      dead_zone_in  = dead_zone_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_SEL_ROVER_MODE: rover_mode_in = pwdata[0];
            REG_SEL_DEAD_ZONE:  dead_zone_in  = pwdata[DZ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SEL_ROVER_MODE: prdata = PDATA_W'(rover_mode_ff);
         REG_SEL_DEAD_ZONE:  prdata = PDATA_W'(dead_zone_ff);
         default:            prdata = '0;
      endcase
   end

   // input side
   logic          req_accept;
   logic          is_cal, is_angle, is_thrust, ch_in_range;
   logic [AW-1:0] req_addr;
   cal_entry_type wr_entry;
   cal_entry_type rd_entry;
   logic [NUM_CHANNELS-1:0] entry_valid_ff, entry_valid_in;
   logic          ram_wr_en, ram_rd_en;

   assign req_accept  = req_valid && !req_stall;
   assign is_cal      = req_word.action == ACTION_CAL;
   assign is_angle    = req_word.action == ACTION_ANGLE;
   assign is_thrust   = req_word.action == ACTION_THRUST;
   assign ch_in_range = CHK_W'(req_word.channel) < NUM_CH;
   assign req_addr    = AW'(req_word.channel);
   assign ram_wr_en   = req_accept && is_cal && ch_in_range;
   assign ram_rd_en   = req_accept && is_angle;

   assign wr_entry.cal_min     = req_word.cal_min;
   assign wr_entry.cal_max     = req_word.cal_max;
   assign wr_entry.cal_neutral = req_word.cal_neutral;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ram_wr_en) begin
         entry_valid_in[req_addr] = 1'b1;
      end
   end

   scm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CHANNELS)
   ) cal_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_addr),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (rd_entry)
   );

   // stage 1: table data arrives, multiply or form dividends
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_thrust_ff;
   logic [CH_W-1:0]    s1_ch_ff;
   logic [ANGLE_W-1:0] s1_angle_ff;
   logic               s1_in_range_ff;
   logic               s1_known_ff;
   logic               s1_load, s1_adv, s1_go_divide;

   cal_entry_type      entry;
   logic [VALUE_W-1:0] len;
   logic [PROD_W-1:0]  angle_prod;
   logic               angle_err;
   logic [DZ_W-2:0]    half;
   logic [DIVISOR_W-1:0] divisor;
   logic [ANGLE_W:0]   thr_floor, thr_diff;
   logic [PROD_W-1:0]  thr_num, brk_num;

   assign s1_load      = req_accept && (is_angle || is_thrust);
   assign s1_go_divide = s1_thrust_ff && rover_mode_ff;

   assign entry      = s1_known_ff ? rd_entry : '0;
   assign len        = (s1_angle_ff > ANGLE_W'(ANGLE_NEUTRAL))
                       ? entry.cal_max - entry.cal_neutral
                       : entry.cal_neutral - entry.cal_min;
   assign angle_prod = PROD_W'(len) * PROD_W'(s1_angle_ff);
   assign angle_err  = !s1_in_range_ff ||
                       (rover_mode_ff && (s1_ch_ff < CH_W'(ROVER_FIXED_CHANNELS)));

   assign half      = dead_zone_ff[DZ_W-1:1];
   assign divisor   = DIVISOR_W'(ANGLE_NEUTRAL) - DIVISOR_W'(half);
   assign thr_floor = (ANGLE_W+1)'(ANGLE_NEUTRAL) + (ANGLE_W+1)'(half);
   // throttle counts only above neutral plus half the dead zone
   assign thr_diff  = ({1'b0, s1_angle_ff} > thr_floor)
                      ? {1'b0, s1_angle_ff} - thr_floor : '0;
   assign thr_num   = PROD_W'(thr_diff) * PROD_W'(FULL_SCALE);
   assign brk_num   = PROD_W'(s1_angle_ff) * PROD_W'(FULL_SCALE);

   // stage 2: result generation
   s2_state_type       state_ff, state_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [CH_W-1:0]    s2_ch_ff;
   logic               s2_err_ff;
   logic [PROD_W-1:0]  s2_prod_ff;
   logic [VALUE_W-1:0] s2_mid_ff, s2_len_ff;
   logic               s2_take, rsp_free, emit_single, emit_thrust;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               div_start, div_busy, div_done, brk_busy, brk_done;
   logic [PROD_W-1:0]  thr_q, brk_q;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign emit_single = (state_ff == S2_SINGLE) && rsp_free;
   assign emit_thrust = (state_ff == S2_THRUST) && rsp_free;
   assign s2_take     = (state_ff == S2_IDLE) || emit_single ||
                        (emit_thrust && (cnt_ff == THRUST_SLOT_BRAKE));
   assign s1_adv      = s1_valid_ff && s2_take;
   assign req_stall   = s1_valid_ff && !s2_take;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s1_adv);
   assign div_start   = s1_adv && s1_go_divide;

   scm_div #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (DIVISOR_W),
      .STEP_BITS  (DIV_STEP_BITS)
   ) thr_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (thr_num),
      .divisor  (divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (thr_q)
   );

   scm_div #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (DIVISOR_W),
      .STEP_BITS  (DIV_STEP_BITS)
   ) brk_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (brk_num),
      .divisor  (divisor),
      .busy     (brk_busy),
      .done     (brk_done),
      .quotient (brk_q)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      priority if (s2_take) begin
         state_in = s1_valid_ff ? (s1_go_divide ? S2_DIVIDE : S2_SINGLE) : S2_IDLE;
      end else if ((state_ff == S2_DIVIDE) && div_done && brk_done) begin
         state_in = S2_THRUST;
         cnt_in   = '0;
      end else if (emit_thrust) begin
         cnt_in = cnt_ff + 2'd1;
      end else begin
         state_in = state_ff;
      end
   end

   // result formation
   logic [VALUE_W-1:0] single_value, brake_value, thrust_value;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // both angle halves reduce to mid + part - len, modulo 2^16
   assign single_value = s2_err_ff ? '0
                         : s2_mid_ff + s2_prod_ff[PART_SHIFT +: VALUE_W] - s2_len_ff;
   assign brake_value  = (brk_q >= PROD_W'(FULL_SCALE)) ? '0
                         : FULL_SCALE - brk_q[VALUE_W-1:0];

   always_comb begin
      unique case (cnt_ff)
         THRUST_SLOT_THROTTLE: thrust_value = thr_q[VALUE_W-1:0];
         THRUST_SLOT_BRAKE:    thrust_value = brake_value;
         default:              thrust_value = '0;
      endcase
   end

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (emit_single) begin
         rsp_word_in.out_channel   = s2_ch_ff;
         rsp_word_in.compare_value = single_value;
         rsp_word_in.error         = s2_err_ff;
         rsp_word_in.last          = 1'b1;
      end else if (emit_thrust) begin
         rsp_word_in.out_channel   = CH_W'(cnt_ff);
         rsp_word_in.compare_value = thrust_value;
         rsp_word_in.error         = 1'b0;
         rsp_word_in.last          = cnt_ff == THRUST_SLOT_BRAKE;
      end
   end

   assign rsp_valid_in = emit_single || emit_thrust || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rover_mode_ff  <= 1'b0;
         dead_zone_ff   <= '0;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
         state_ff       <= S2_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rover_mode_ff  <= rover_mode_in;
         dead_zone_ff   <= dead_zone_in;
         entry_valid_ff <= entry_valid_in;
         s1_valid_ff    <= s1_valid_in;
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_thrust_ff   <= is_thrust;
         s1_ch_ff       <= req_word.channel;
         s1_angle_ff    <= req_word.angle;
         s1_in_range_ff <= ch_in_range;
         s1_known_ff    <= entry_valid_ff[req_addr];
      end
      if (s1_adv) begin
         s2_ch_ff   <= s1_thrust_ff ? '0 : s1_ch_ff;
         s2_err_ff  <= s1_thrust_ff ? !rover_mode_ff : angle_err;
         s2_prod_ff <= angle_prod;
         s2_mid_ff  <= entry.cal_neutral;
         s2_len_ff  <= len;
      end
      rsp_word_ff <= rsp_word_in;
   end

   `SCM_ASSERT_HOLDS(a_div_only_in_divide, clock, reset, div_busy || brk_busy, state_ff == S2_DIVIDE)
   `SCM_ASSERT_HOLDS(a_not_last_from_thrust, clock, reset, rsp_valid_ff && !rsp_word_ff.last, state_ff == S2_THRUST)
   `SCM_ASSERT_NEXT(a_item_enters_stage1, clock, reset, req_accept && (is_angle || is_thrust), s1_valid_ff)

endmodule

// File: test/tb.sv
// self-checking testbench of the servo command mapper unit
`timescale 1ns / 1ps

module tb;
   import scm_pkg::*;

   localparam int          NUM_CH        = NUM_CHANNELS_DEFAULT;
   localparam int unsigned FULL_SCALE    = SERVO_FULL_SCALE_DEFAULT;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 20;
   localparam int          DRAIN_CYCLES  = 30;

   localparam logic [ACTION_W-1:0] ACTION_UNUSED   = 2'd3;
   localparam logic [PADDR_W-1:0]  ADDR_ROVER_MODE = 3'd0;
   localparam logic [PADDR_W-1:0]  ADDR_DEAD_ZONE  = 3'd4;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_word_type       req_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_word_type       rsp_word;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // predictor state, table cleared as after reset
   cal_entry_type      cal_table [NUM_CH] = '{default: '0};
   logic               rover_mode = 1'b0;
   logic [DZ_W-1:0]    dead_zone = '0;
   rsp_word_type       expected_words [$];

   int                 error_count = 0;
   int unsigned        cycle_count = 0;
   bit                 req_idle_en = 1'b1;
   bit                 rsp_idle_en = 1'b1;
   int                 stall_left = 0;

   servo_command_mapper_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] map_angle_value(input cal_entry_type e,
                                                           input logic [ANGLE_W-1:0] ang);
      logic [VALUE_W-1:0] span;
      logic [31:0]        part;
      logic [31:0]        sum;
      if (ang > ANGLE_NEUTRAL) begin
         span = e.cal_max - e.cal_neutral;
         part = (32'(span) * 32'(ang)) >> PART_SHIFT;
         sum  = 32'(e.cal_neutral) + part - 32'(span);
      end else begin
         span = e.cal_neutral - e.cal_min;
         part = (32'(span) * 32'(ang)) >> PART_SHIFT;
         sum  = 32'(e.cal_neutral) - (32'(span) - part);
      end
      return sum[VALUE_W-1:0];
   endfunction

   function automatic rsp_word_type make_rsp(input int ch, input int unsigned val,
                                             input bit err, input bit fin);
      rsp_word_type r;
      r.out_channel   = ch[CH_W-1:0];
      r.compare_value = val[VALUE_W-1:0];
      r.error         = err;
      r.last          = fin;
      return r;
   endfunction

   // works out the words that one accepted command causes
   task automatic predict_servo_words(input req_word_type w);
      int unsigned half, dvs, thr, brk;
      int          diff;
      case (w.action)
         ACTION_CAL: begin
            if (int'(w.channel) < NUM_CH) begin
               cal_table[w.channel].cal_min     = w.cal_min;
               cal_table[w.channel].cal_max     = w.cal_max;
               cal_table[w.channel].cal_neutral = w.cal_neutral;
            end
         end
         ACTION_ANGLE: begin
            if (int'(w.channel) >= NUM_CH ||
                (rover_mode && int'(w.channel) < ROVER_FIXED_CHANNELS))
               expected_words.push_back(make_rsp(w.channel, 0, 1'b1, 1'b1));
            else
               expected_words.push_back(make_rsp(w.channel,
                  map_angle_value(cal_table[w.channel], w.angle), 1'b0, 1'b1));
         end
         ACTION_THRUST: begin
            if (!rover_mode) begin
               expected_words.push_back(make_rsp(0, 0, 1'b1, 1'b1));
            end else begin
               half = dead_zone >> 1;
               dvs  = ANGLE_NEUTRAL - half;
               diff = int'(w.angle) - int'(ANGLE_NEUTRAL + half);
               if (diff < 0) diff = 0;
               if (diff > 255) diff = 255;
               thr = (int'(diff) * FULL_SCALE) / dvs;
               brk = (FULL_SCALE * w.angle) / dvs;
               brk = (brk >= FULL_SCALE) ? 0 : FULL_SCALE - brk;
               if (brk > 16'hFFFF) brk = 16'hFFFF;
               expected_words.push_back(make_rsp(0, 0, 1'b0, 1'b0));
               expected_words.push_back(make_rsp(1, 0, 1'b0, 1'b0));
               expected_words.push_back(make_rsp(THRUST_SLOT_THROTTLE, thr, 1'b0, 1'b0));
               expected_words.push_back(make_rsp(THRUST_SLOT_BRAKE, brk, 1'b0, 1'b1));
            end
         end
         default: ;
      endcase
   endtask

   // result side: random stall and comparison against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: channel %0d value %0d",
                      rsp_word.out_channel, rsp_word.compare_value);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.out_channel !== want.out_channel) begin
                  $error("out_channel: expected %0d, actual %0d",
                         want.out_channel, rsp_word.out_channel);
                  error_count++;
               end
               if (rsp_word.compare_value !== want.compare_value) begin
                  $error("compare_value: expected %0d, actual %0d",
                         want.compare_value, rsp_word.compare_value);
                  error_count++;
               end
               if (rsp_word.error !== want.error) begin
                  $error("error: expected %0d, actual %0d", want.error, rsp_word.error);
                  error_count++;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_word.last);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_en && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_word(input req_word_type w);
      int gap;
      gap = (req_idle_en && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_servo_words(w);
   endtask

   // lowers valid and waits until every expected word has come back
   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_ROVER_MODE) rover_mode = data[0];
      else dead_zone = data[DZ_W-1:0];
   endtask

   task automatic set_mode(input logic rover, input logic [DZ_W-1:0] dz);
      wait_drained(SETTLE_CYCLES);
      csr_write(ADDR_ROVER_MODE, PDATA_W'(rover));
      csr_write(ADDR_DEAD_ZONE, PDATA_W'(dz));
   endtask

   function automatic req_word_type mk(input logic [ACTION_W-1:0] act, input int ch,
                                       input int ang, input int mn = 0,
                                       input int mx = 0, input int nt = 0);
      req_word_type w;
      w.action      = act;
      w.channel     = ch[CH_W-1:0];
      w.angle       = ang[ANGLE_W-1:0];
      w.cal_min     = mn[VALUE_W-1:0];
      w.cal_max     = mx[VALUE_W-1:0];
      w.cal_neutral = nt[VALUE_W-1:0];
      return w;
   endfunction

   function automatic req_word_type random_command();
      req_word_type w;
      int           r;
      int           nt;
      r = $urandom_range(0, 99);
      w.channel     = $urandom_range(0, 7);
      w.cal_min     = $urandom_range(0, 16'hFFFF);
      w.cal_max     = $urandom_range(0, 16'hFFFF);
      w.cal_neutral = $urandom_range(0, 16'hFFFF);
      case ($urandom_range(0, 9))
         0: w.angle = ANGLE_NEUTRAL;
         1: w.angle = $urandom_range(0, 1) ? 8'd0 : 8'd255;
         2: w.angle = ANGLE_NEUTRAL + $urandom_range(0, 2) - 1;
         default: w.angle = $urandom_range(0, 255);
      endcase
      if (r < 25) begin
         w.action = ACTION_CAL;
         // mostly ordered servo calibrations, the rest arbitrary
         if ($urandom_range(0, 99) < 65) begin
            nt            = $urandom_range(4000, 60000);
            w.cal_neutral = nt;
            w.cal_min     = nt - $urandom_range(0, 4000);
            w.cal_max     = nt + $urandom_range(0, 5000);
         end
      end else if (r < 65) begin
         w.action = ACTION_ANGLE;
         if (rover_mode) w.channel = $urandom_range(ROVER_FIXED_CHANNELS, NUM_CH - 1);
      end else if (r < 88) begin
         w.action = ACTION_THRUST;
      end else if (r < 93) begin
         w.action = ACTION_UNUSED;
      end else begin
         w.action = ACTION_ANGLE;
      end
      return w;
   endfunction

   // table is cleared at reset
   task automatic test_reset_table();
      send_word(mk(ACTION_ANGLE, 5, 0));
      send_word(mk(ACTION_ANGLE, 7, 255));
   endtask

   task automatic test_angle_extremes();
      send_word(mk(ACTION_CAL, 4, 0, 0, 16'hFFFF, 16'h8000));
      send_word(mk(ACTION_ANGLE, 4, 0));
      send_word(mk(ACTION_ANGLE, 4, ANGLE_NEUTRAL));
      send_word(mk(ACTION_ANGLE, 4, ANGLE_NEUTRAL + 1));
      send_word(mk(ACTION_ANGLE, 4, 255));
      // min above neutral and max below it: spans wrap
      send_word(mk(ACTION_CAL, 6, 0, 16'hFFFF, 0, 16'h1234));
      send_word(mk(ACTION_ANGLE, 6, 64));
      send_word(mk(ACTION_ANGLE, 6, 200));
   endtask

   task automatic test_plane_rejects();
      send_word(mk(ACTION_UNUSED, 7, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_word(mk(ACTION_THRUST, 0, 200));
   endtask

   task automatic test_rover_mode();
      set_mode(1'b1, 8'd0);
      send_word(mk(ACTION_ANGLE, 0, 100));
      send_word(mk(ACTION_ANGLE, 3, 255));
      send_word(mk(ACTION_ANGLE, 4, 0));
      send_word(mk(ACTION_THRUST, 2, 0));
      send_word(mk(ACTION_THRUST, 5, ANGLE_NEUTRAL));
      send_word(mk(ACTION_THRUST, 7, 255));
      set_mode(1'b1, 8'd255);
      send_word(mk(ACTION_THRUST, 0, 255));
      send_word(mk(ACTION_THRUST, 1, 200));
   endtask

   task automatic test_random_phases();
      logic            modes [6];
      logic [DZ_W-1:0] zones [6];
      modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      zones = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0};
      zones[4] = $urandom_range(1, 254);
      modes[5] = $urandom_range(0, 1);
      zones[5] = $urandom_range(0, 255);
      for (int p = 0; p < 6; p++) begin
         set_mode(modes[p], zones[p]);
         // one phase runs flat out on both sides
         req_idle_en = (p != 3);
         rsp_idle_en = (p != 3);
         for (int i = 0; i < 52; i++) begin
            if (p == 2 && i == 26) wait_drained(0);
            send_word(random_command());
         end
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_table();
      test_angle_extremes();
      test_plane_rejects();
      test_rover_mode();
      test_random_phases();
      wait_drained(DRAIN_CYCLES);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
